@@ src/luma_alias_table_builder_macros.svh @@
// Assertion macros for the luma alias-table builder checker.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef LUMA_ALIAS_TABLE_BUILDER_MACROS_SVH
`define LUMA_ALIAS_TABLE_BUILDER_MACROS_SVH

// same-cycle implication
`define LATB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("latb assertion failed");

// next-cycle implication
`define LATB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("latb assertion failed");

`endif

@@ src/latb_pkg.sv @@
// Types and constants for the luma alias-table builder.
// No dependencies.
package latb_pkg;

   localparam int LUMA_W = 17;
   localparam int ACC_W  = 34;

   localparam logic [15:0]      COEF_R     = 16'd13933;
   localparam logic [15:0]      COEF_G     = 16'd46872;
   localparam logic [15:0]      COEF_B     = 16'd4732;
   localparam logic [ACC_W-1:0] ROUND_HALF = 34'h0_0000_8000;
   localparam logic [16:0]      ONE_Q16    = 17'h1_0000;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_BUILT = 2'd1,
      ST_RANGE     = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LD_MUL,
      S_LD_WR,
      S_SC_RD,
      S_SC_MUL,
      S_SC_NUM,
      S_SC_DIV,
      S_SC_WR,
      S_CL_RD,
      S_CL_WR,
      S_PR_RDL,
      S_PR_RDG,
      S_PR_IMPL,
      S_PR_IMPG,
      S_PR_UPD,
      S_LF_RD,
      S_LF_WR,
      S_RD_MEM,
      S_RD_DATA,
      S_DONE
   } state_type;

endpackage

@@ src/luma_alias_table_builder.sv @@
// Luma alias-table builder: pixel loader, scaler/divider and alias sequencer.
// Depends on latb_pkg.
//
// Requests come in on req_*: tuser is the opcode (load a pixel or read an entry),
// tlast marks the last pixel of a map and starts the table build. Every request
// gives exactly one response on rsp_*: tuser carries the status, tdata the entry.
// req_tready is high only while the sequencer is idle; one request is in flight.
// Per request:
//   load            three products through the shared multiplier
//   read            memory read, then the response; errors go straight to the response
//   build (on last) scale, classify, pair and leftover passes over the entries;
//                   the bit-serial divider works out a NUM_W-bit quotient for each entry,
//                   one quotient bit per cycle; NUM_W = 47 at the default size.
// All memories share one read and one write port each, so a build walks the
// entries one at a time. The response waits in an output register while
// rsp_tready is low; the sequencer holds in its final state until it is free.
// Reset clears the pixel count, the luma total, the table-ready flag and the
// handshake state; table contents are undefined until a build writes them.
module luma_alias_table_builder #(
   parameter int MAX_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tlast,   // last_pixel
   input  logic        req_tuser,   // opcode
   input  logic [63:0] req_tdata,   // red[15:0], green[31:16], blue[47:32], read_index[59:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [63:0] rsp_tdata    // pdf[28:0], accept_prob[45:29], alias_index[57:46]
);

   localparam int IDX_W = $clog2(MAX_PIXELS);
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int TOT_W = latb_pkg::LUMA_W + IDX_W;
   localparam int QW    = 16 + CNT_W;
   localparam int IMP_W = QW;
   localparam int MA_W  = latb_pkg::LUMA_W;
   localparam int MB_W  = (CNT_W > 16) ? CNT_W : 16;
   localparam int PW    = MA_W + MB_W;
   localparam int NUM_W = latb_pkg::LUMA_W + CNT_W + 17;
   localparam int DC_W  = $clog2(NUM_W + 1);
   localparam int CW    = (CNT_W > 12) ? CNT_W : 12;

   // memories
   logic [IMP_W-1:0] imp_mem   [MAX_PIXELS];
   logic [QW-1:0]    pdf_mem   [MAX_PIXELS];
   logic [16:0]      prob_mem  [MAX_PIXELS];
   logic [IDX_W-1:0] alias_mem [MAX_PIXELS];
   logic [IDX_W-1:0] wl_mem    [MAX_PIXELS];

   logic [IMP_W-1:0] imp_rd;
   logic [QW-1:0]    pdf_rd;
   logic [16:0]      prob_rd;
   logic [IDX_W-1:0] alias_rd;
   logic [IDX_W-1:0] wl_rd;

   logic             imp_we, pdf_we, pa_we, wl_we;
   logic [IDX_W-1:0] imp_waddr, imp_raddr, pdf_waddr, rd_raddr, pa_waddr;
   logic [IDX_W-1:0] wl_waddr, wl_raddr;
   logic [IMP_W-1:0] imp_wdata;
   logic [QW-1:0]    pdf_wdata;
   logic [16:0]      prob_wdata;
   logic [IDX_W-1:0] alias_wdata, wl_wdata;

   // control and datapath registers
   latb_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic                 ready_ff, ready_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   latb_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [63:0]          rsp_data_ff, rsp_data_in;

   latb_pkg::status_type res_status_ff, res_status_in;
   logic [63:0]          res_data_ff, res_data_in;
   logic [15:0]          red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                 last_ff, last_in;
   logic [11:0]          idx_ff, idx_in;
   logic [1:0]           step_ff, step_in;
   logic [latb_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [CNT_W-1:0]     i_ff, i_in, s_ff, s_in, lg_ff, lg_in;
   logic [TOT_W:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DC_W-1:0]      dc_ff, dc_in;
   logic [IDX_W-1:0]     l_ff, l_in, g_ff, g_in;
   logic [IMP_W-1:0]     impl_ff, impl_in;

   // shared multiplier
   logic [MA_W-1:0] mul_a;
   logic [MB_W-1:0] mul_b;

   logic                 accept;
   logic [CNT_W-1:0]     cnt_eff;
   logic [TOT_W:0]       div_t;
   logic [IMP_W-1:0]     scaled;
   logic [IMP_W-1:0]     merged;
   logic [latb_pkg::LUMA_W-1:0] luma;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == latb_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cnt_eff = ready_ff ? '0 : cnt_ff;
   assign div_t   = {rem_ff[TOT_W-1:0], quo_ff[NUM_W-1]};
   assign scaled  = (total_ff == '0) ? IMP_W'(latb_pkg::ONE_Q16) : IMP_W'(quo_ff);
   assign merged  = imp_rd + impl_ff - IMP_W'(latb_pkg::ONE_Q16);
   assign luma    = acc_ff[16 +: latb_pkg::LUMA_W];
   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      mul_a = MA_W'(imp_rd);
      mul_b = MB_W'(cnt_ff);
      if (state_ff == latb_pkg::S_LD_MUL) begin
         case (step_ff)
            2'd0:    begin mul_a = MA_W'(red_ff);   mul_b = MB_W'(latb_pkg::COEF_R); end
            2'd1:    begin mul_a = MA_W'(green_ff); mul_b = MB_W'(latb_pkg::COEF_G); end
            default: begin mul_a = MA_W'(blue_ff);  mul_b = MB_W'(latb_pkg::COEF_B); end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         latb_pkg::S_IDLE: begin
            if (accept) begin
               if (req_tuser == latb_pkg::OP_LOAD) begin
                  if (CW'(cnt_eff) >= CW'(MAX_PIXELS)) begin
                     state_in = (req_tlast && cnt_eff != '0) ? latb_pkg::S_SC_RD
                                                             : latb_pkg::S_DONE;
                  end else begin
                     state_in = latb_pkg::S_LD_MUL;
                  end
               end else if (!ready_ff || CW'(req_tdata[59:48]) >= CW'(cnt_ff)) begin
                  state_in = latb_pkg::S_DONE;
               end else begin
                  state_in = latb_pkg::S_RD_MEM;
               end
            end
         end
         latb_pkg::S_LD_MUL:  if (step_ff == 2'd3) state_in = latb_pkg::S_LD_WR;
         latb_pkg::S_LD_WR:   state_in = last_ff ? latb_pkg::S_SC_RD : latb_pkg::S_DONE;
         latb_pkg::S_SC_RD:   state_in = (total_ff == '0) ? latb_pkg::S_SC_WR
                                                          : latb_pkg::S_SC_MUL;
         latb_pkg::S_SC_MUL:  state_in = latb_pkg::S_SC_NUM;
         latb_pkg::S_SC_NUM:  state_in = latb_pkg::S_SC_DIV;
         latb_pkg::S_SC_DIV:  if (dc_ff == DC_W'(NUM_W - 1)) state_in = latb_pkg::S_SC_WR;
         latb_pkg::S_SC_WR:   state_in = (i_ff + 1'b1 == cnt_ff) ? latb_pkg::S_CL_RD
                                                                 : latb_pkg::S_SC_RD;
         latb_pkg::S_CL_RD:   state_in = latb_pkg::S_CL_WR;
         latb_pkg::S_CL_WR:   state_in = (i_ff + 1'b1 == cnt_ff) ? latb_pkg::S_PR_RDL
                                                                 : latb_pkg::S_CL_RD;
         latb_pkg::S_PR_RDL:  state_in = (s_ff != '0 && lg_ff != '0) ? latb_pkg::S_PR_RDG
                                                                     : latb_pkg::S_LF_RD;
         latb_pkg::S_PR_RDG:  state_in = latb_pkg::S_PR_IMPL;
         latb_pkg::S_PR_IMPL: state_in = latb_pkg::S_PR_IMPG;
         latb_pkg::S_PR_IMPG: state_in = latb_pkg::S_PR_UPD;
         latb_pkg::S_PR_UPD:  state_in = latb_pkg::S_PR_RDL;
         latb_pkg::S_LF_RD:   state_in = (s_ff == '0 && lg_ff == '0) ? latb_pkg::S_DONE
                                                                     : latb_pkg::S_LF_WR;
         latb_pkg::S_LF_WR:   state_in = latb_pkg::S_LF_RD;
         latb_pkg::S_RD_MEM:  state_in = latb_pkg::S_RD_DATA;
         latb_pkg::S_RD_DATA: state_in = latb_pkg::S_DONE;
         latb_pkg::S_DONE:    if (!rsp_valid_ff || rsp_tready) state_in = latb_pkg::S_IDLE;
         default:             state_in = latb_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      ready_in      = ready_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      i_in          = i_ff;
      s_in          = s_ff;
      lg_in         = lg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dc_in         = dc_ff;
      l_in          = l_ff;
      g_in          = g_ff;
      impl_in       = impl_ff;

      imp_we      = 1'b0;
      imp_waddr   = IDX_W'(i_ff);
      imp_wdata   = scaled;
      imp_raddr   = IDX_W'(i_ff);
      pdf_we      = 1'b0;
      pdf_waddr   = IDX_W'(i_ff);
      pdf_wdata   = QW'(scaled);
      rd_raddr    = IDX_W'(idx_ff);
      pa_we       = 1'b0;
      pa_waddr    = l_ff;
      prob_wdata  = 17'(impl_ff);
      alias_wdata = g_ff;
      wl_we       = 1'b0;
      wl_waddr    = IDX_W'(s_ff);
      wl_wdata    = IDX_W'(i_ff);
      wl_raddr    = IDX_W'(s_ff - 1'b1);

      unique case (state_ff)
         latb_pkg::S_IDLE: begin
            if (accept) begin
               red_in        = req_tdata[15:0];
               green_in      = req_tdata[31:16];
               blue_in       = req_tdata[47:32];
               idx_in        = req_tdata[59:48];
               last_in       = req_tlast;
               res_status_in = latb_pkg::ST_OK;
               res_data_in   = '0;
               step_in       = '0;
               acc_in        = latb_pkg::ROUND_HALF;
               i_in          = '0;
               s_in          = '0;
               lg_in         = '0;
               if (req_tuser == latb_pkg::OP_LOAD) begin
                  // a load after a finished build starts a new map
                  if (ready_ff) begin
                     ready_in = 1'b0;
                     cnt_in   = '0;
                     total_in = '0;
                  end
                  if (CW'(cnt_eff) >= CW'(MAX_PIXELS)) begin
                     res_status_in = latb_pkg::ST_DROPPED;
                  end
               end else if (!ready_ff) begin
                  res_status_in = latb_pkg::ST_NOT_BUILT;
               end else if (CW'(req_tdata[59:48]) >= CW'(cnt_ff)) begin
                  res_status_in = latb_pkg::ST_RANGE;
               end
            end
         end
         latb_pkg::S_LD_MUL: begin
            if (step_ff != 2'd0) begin
               acc_in = acc_ff + latb_pkg::ACC_W'(prod_ff);
            end
            step_in = step_ff + 1'b1;
         end
         latb_pkg::S_LD_WR: begin
            imp_we    = 1'b1;
            imp_waddr = IDX_W'(cnt_ff);
            imp_wdata = IMP_W'(luma);
            total_in  = total_ff + TOT_W'(luma);
            cnt_in    = cnt_ff + 1'b1;
         end
         latb_pkg::S_SC_NUM: begin
            rem_in = '0;
            dc_in  = '0;
            quo_in = NUM_W'({prod_ff[MA_W + CNT_W - 1:0], 16'h0000}) + NUM_W'(total_ff >> 1);
         end
         latb_pkg::S_SC_DIV: begin
            // restoring division, one quotient bit a cycle
            if (div_t >= (TOT_W + 1)'(total_ff)) begin
               rem_in = div_t - (TOT_W + 1)'(total_ff);
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_t;
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            dc_in = dc_ff + 1'b1;
         end
         latb_pkg::S_SC_WR: begin
            imp_we = 1'b1;
            pdf_we = 1'b1;
            i_in   = (i_ff + 1'b1 == cnt_ff) ? '0 : i_ff + 1'b1;
         end
         latb_pkg::S_CL_WR: begin
            wl_we = 1'b1;
            if (imp_rd < IMP_W'(latb_pkg::ONE_Q16)) begin
               wl_waddr = IDX_W'(s_ff);
               s_in     = s_ff + 1'b1;
            end else begin
               wl_waddr = IDX_W'(cnt_ff - lg_ff - 1'b1);
               lg_in    = lg_ff + 1'b1;
            end
            i_in = i_ff + 1'b1;
         end
         latb_pkg::S_PR_RDL: begin
            wl_raddr = IDX_W'(s_ff - 1'b1);
         end
         latb_pkg::S_PR_RDG: begin
            l_in     = wl_rd;
            wl_raddr = IDX_W'(cnt_ff - lg_ff);
         end
         latb_pkg::S_PR_IMPL: begin
            g_in      = wl_rd;
            imp_raddr = l_ff;
         end
         latb_pkg::S_PR_IMPG: begin
            impl_in   = imp_rd;
            imp_raddr = g_ff;
         end
         latb_pkg::S_PR_UPD: begin
            pa_we     = 1'b1;
            imp_we    = 1'b1;
            imp_waddr = g_ff;
            imp_wdata = merged;
            wl_we     = 1'b1;
            wl_wdata  = g_ff;
            // pop both lists, push the donor back where it now belongs
            if (merged < IMP_W'(latb_pkg::ONE_Q16)) begin
               wl_waddr = IDX_W'(s_ff - 1'b1);
               lg_in    = lg_ff - 1'b1;
            end else begin
               wl_waddr = IDX_W'(cnt_ff - lg_ff);
               s_in     = s_ff - 1'b1;
            end
         end
         latb_pkg::S_LF_RD: begin
            wl_raddr = (s_ff != '0) ? IDX_W'(s_ff - 1'b1) : IDX_W'(cnt_ff - lg_ff);
            if (s_ff == '0 && lg_ff == '0) begin
               ready_in = 1'b1;
            end
         end
         latb_pkg::S_LF_WR: begin
            pa_we       = 1'b1;
            pa_waddr    = wl_rd;
            prob_wdata  = latb_pkg::ONE_Q16;
            alias_wdata = wl_rd;
            if (s_ff != '0) begin
               s_in = s_ff - 1'b1;
            end else begin
               lg_in = lg_ff - 1'b1;
            end
         end
         latb_pkg::S_RD_DATA: begin
            res_data_in = {6'b0, 12'(alias_rd), prob_rd, 29'(pdf_rd)};
         end
         latb_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= latb_pkg::S_IDLE;
         cnt_ff       <= '0;
         total_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      i_ff          <= i_in;
      s_ff          <= s_in;
      lg_ff         <= lg_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dc_ff         <= dc_in;
      l_ff          <= l_in;
      g_ff          <= g_in;
      impl_ff       <= impl_in;
   end

   always_ff @(posedge clock) begin
      if (imp_we) begin
         imp_mem[imp_waddr] <= imp_wdata;
      end
      imp_rd <= imp_mem[imp_raddr];
   end

   always_ff @(posedge clock) begin
      if (pdf_we) begin
         pdf_mem[pdf_waddr] <= pdf_wdata;
      end
      pdf_rd <= pdf_mem[rd_raddr];
   end

   always_ff @(posedge clock) begin
      if (pa_we) begin
         prob_mem[pa_waddr] <= prob_wdata;
      end
      prob_rd <= prob_mem[rd_raddr];
   end

   always_ff @(posedge clock) begin
      if (pa_we) begin
         alias_mem[pa_waddr] <= alias_wdata;
      end
      alias_rd <= alias_mem[rd_raddr];
   end

   always_ff @(posedge clock) begin
      if (wl_we) begin
         wl_mem[wl_waddr] <= wl_wdata;
      end
      wl_rd <= wl_mem[wl_raddr];
   end

endmodule

@@ src/latb_checker.sv @@
// Port-level checker for the luma alias-table builder, bound to its top level.
// Depends on latb_pkg and luma_alias_table_builder_macros.svh.
`include "luma_alias_table_builder_macros.svh"

module latb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [63:0] rsp_tdata
);

   // one request in flight: no accept in the cycle after an accept
   `LATB_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)

   // a failed request answers with an all-zero entry
   `LATB_ASSERT_IMPL(a_err_zero, rsp_tvalid && rsp_tuser != latb_pkg::ST_OK, rsp_tdata == 64'd0)

   // accept probability never exceeds one
   `LATB_ASSERT_IMPL(a_prob_range, rsp_tvalid, rsp_tdata[45:29] <= 17'h1_0000)

   // a stalled response is held
   `LATB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind luma_alias_table_builder latb_checker u_latb_checker (.*);

@@ sim/tb_luma_alias_table_builder.sv @@
// Self-checking bench for the luma alias-table builder: random pixel maps and reads
// against an alias-table predictor kept in a small scoreboard class.
// Depends on latb_pkg and luma_alias_table_builder.
module tb_luma_alias_table_builder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPIX = 4096;

   typedef struct packed {
      logic [1:0]  status;
      logic [28:0] pdf;
      logic [16:0] prob;
      logic [11:0] alias_idx;
   } entry_result_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class alias_scoreboard;
      logic [35:0] imp [NPIX];
      logic [28:0] pdf_tab [NPIX];
      logic [16:0] prob_tab [NPIX];
      logic [11:0] alias_tab [NPIX];
      int unsigned work [NPIX];
      int unsigned pixel_count = 0;
      longint unsigned luma_total = 0;
      bit ready = 0;
      entry_result_type pending[$];

      function void build_table();
         int unsigned n, s, lg, l, g;
         longint unsigned v;
         n = pixel_count; s = 0; lg = 0;
         for (int i = 0; i < n; i++) begin
            if (luma_total == 0) v = 65536;
            else v = (longint'(imp[i]) * n * 65536 + luma_total / 2) / luma_total;
            imp[i] = 36'(v);
            pdf_tab[i] = v[28:0];
         end
         for (int i = 0; i < n; i++) begin
            if (imp[i] < 65536) begin
               work[s] = i; s++;
            end else begin
               work[n - 1 - lg] = i; lg++;
            end
         end
         while (s > 0 && lg > 0) begin
            s--; l = work[s];
            g = work[n - lg]; lg--;
            prob_tab[l] = imp[l][16:0];
            alias_tab[l] = 12'(g);
            imp[g] = imp[g] + imp[l] - 36'd65536;
            if (imp[g] < 65536) begin
               work[s] = g; s++;
            end else begin
               work[n - 1 - lg] = g; lg++;
            end
         end
         while (s > 0) begin
            s--; l = work[s];
            prob_tab[l] = 17'h10000; alias_tab[l] = 12'(l);
         end
         while (lg > 0) begin
            g = work[n - lg]; lg--;
            prob_tab[g] = 17'h10000; alias_tab[g] = 12'(g);
         end
         ready = 1;
      endfunction

      function void note_request(input logic op, input logic [15:0] r, input logic [15:0] gr,
                                 input logic [15:0] b, input logic last, input logic [11:0] idx);
         entry_result_type e;
         longint unsigned luma;
         e = '0;
         if (op == latb_pkg::OP_LOAD) begin
            if (ready) begin
               ready = 0; pixel_count = 0; luma_total = 0;
            end
            if (pixel_count >= NPIX) e.status = latb_pkg::ST_DROPPED;
            else begin
               luma = (longint'(r) * 13933 + longint'(gr) * 46872 + longint'(b) * 4732
                       + 32768) >> 16;
               imp[pixel_count] = 36'(luma);
               luma_total += luma;
               pixel_count++;
            end
            if (last && pixel_count > 0) build_table();
         end else if (!ready) e.status = latb_pkg::ST_NOT_BUILT;
         else if (idx >= pixel_count) e.status = latb_pkg::ST_RANGE;
         else begin
            e.pdf = pdf_tab[idx]; e.prob = prob_tab[idx]; e.alias_idx = alias_tab[idx];
         end
         pending = {pending, e};
      endfunction

      task check_response(input logic [1:0] st, input logic [63:0] d);
         entry_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response status", st, -1);
            return;
         end
         e = pending.pop_front();
         if (st !== e.status) report_mismatch("status", st, e.status);
         if (d[28:0] !== e.pdf) report_mismatch("pdf", d[28:0], e.pdf);
         if (d[45:29] !== e.prob) report_mismatch("accept_prob", d[45:29], e.prob);
         if (d[57:46] !== e.alias_idx) report_mismatch("alias_index", d[57:46], e.alias_idx);
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tlast = 0, req_tuser = 0;
   logic [63:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic rsp_tready = 0;
   logic [1:0] rsp_tuser;
   logic [63:0] rsp_tdata;
   bit calm = 0;
   longint unsigned cycles = 0;
   alias_scoreboard sb = new();

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   luma_alias_table_builder u_dut (.*);

   // response side: random stall bursts, none in the calm tail
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 64'd1_000_000) begin
         $display("tb_luma_alias_table_builder: done, errors");
         $finish;
      end
   end

   function automatic logic [15:0] rand_chan();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // drive one request, hold until accepted, then maybe idle
   task automatic send_request(input logic op, input logic [15:0] r, input logic [15:0] g,
                               input logic [15:0] b, input logic last, input logic [11:0] idx);
      int n;
      req_tvalid <= 1;
      req_tuser <= op;
      req_tlast <= last;
      req_tdata <= {4'b0, idx, b, g, r};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, r, g, b, last, idx);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         n = $urandom_range(1, 11);
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic load_pixel(input logic last);
      send_request(latb_pkg::OP_LOAD, rand_chan(), rand_chan(), rand_chan(), last,
                   12'($urandom));
   endtask

   task automatic read_entry(input logic [11:0] idx);
      send_request(latb_pkg::OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), idx);
   endtask

   task automatic random_map(input int unsigned npix, input int unsigned nreads);
      for (int i = 0; i < npix; i++) load_pixel(i == npix - 1);
      for (int i = 0; i < nreads; i++)
         read_entry(12'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, npix)));
   endtask

   initial begin
      int unsigned sent;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: read before build, extremes, zero total, single pixel
      read_entry(12'd0);
      read_entry(12'hFFF);
      send_request(latb_pkg::OP_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 12'd0);
      send_request(latb_pkg::OP_LOAD, 16'h0000, 16'h0000, 16'h0000, 1'b0, 12'd0);
      send_request(latb_pkg::OP_LOAD, 16'h0100, 16'h0000, 16'h0000, 1'b0, 12'd0);
      send_request(latb_pkg::OP_LOAD, 16'h0000, 16'h0100, 16'h0100, 1'b1, 12'hFFF);
      for (int i = 0; i < 5; i++) read_entry(12'(i));
      read_entry(12'hFFF);
      for (int i = 0; i < 3; i++)
         send_request(latb_pkg::OP_LOAD, 16'h0000, 16'h0000, 16'h0000, i == 2, 12'd0);
      for (int i = 0; i < 3; i++) read_entry(12'(i));
      send_request(latb_pkg::OP_LOAD, 16'h1234, 16'h5678, 16'h9ABC, 1'b1, 12'd0);
      read_entry(12'd0);
      read_entry(12'd1);
      // hold off until every response is back
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      sent = 0;
      while (sent < 780) begin
         int unsigned np;
         np = $urandom_range(1, 12);
         random_map(np, np + 3);
         sent += 2 * np + 3;
      end
      calm = 1;
      random_map(8, 40);
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && sb.pending.size() == 0)
         $display("tb_luma_alias_table_builder: done, clean");
      else
         $display("tb_luma_alias_table_builder: done, errors");
      $finish;
   end
endmodule
